// ----- design/nfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfr_pkg
// Shared types and constants of the NAPT flow rewriter.
// ----------------------------------------------------------------------------
package nfr_pkg;

	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [15:0] MIN_TRANSPORT_LEN = 16'd8;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	localparam logic [1:0] ACT_FORWARD = 2'd0;
	localparam logic [1:0] ACT_DROP    = 2'd1;
	localparam logic [1:0] ACT_PASS    = 2'd2;

	localparam logic [1:0] MODE_DROP     = 2'd0;
	localparam logic [1:0] MODE_SAME_RND = 2'd1;
	localparam logic [1:0] MODE_RND      = 2'd2;
	localparam logic [1:0] MODE_SEQ      = 2'd3;

	localparam logic [2:0] REG_NEW_SRC_ADDR = 3'd0;
	localparam logic [2:0] REG_NEW_SRC_PORT = 3'd1;
	localparam logic [2:0] REG_NEW_DST_ADDR = 3'd2;
	localparam logic [2:0] REG_NEW_DST_PORT = 3'd3;
	localparam logic [2:0] REG_PORT_SPAN    = 3'd4;
	localparam logic [2:0] REG_REWRITE_MODE = 3'd5;
	localparam logic [2:0] REG_FORWARD_PORT = 3'd6;
	localparam logic [2:0] REG_REPLY_PORT   = 3'd7;

	typedef struct packed {
		logic [31:0] new_src_addr;
		logic [15:0] new_src_port;
		logic [31:0] new_dst_addr;
		logic [15:0] new_dst_port;
		logic [15:0] port_span;
		logic [1:0]  rewrite_mode;
		logic [2:0]  forward_port;
		logic [2:0]  reply_port;
	} cfg_t;

	typedef struct packed {
		logic        reject;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [2:0]  in_port;
	} item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  out_port;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} res_t;

endpackage

// ----- design/nfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfr_front
// Takes requests, screens protocol/fragment/length and queues them.
// ----------------------------------------------------------------------------
module nfr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        protocol,
	input  logic              first_fragment,
	input  logic [15:0]       transport_len,
	input  logic [31:0]       src_addr,
	input  logic [31:0]       dst_addr,
	input  logic [15:0]       src_port,
	input  logic [15:0]       dst_port,
	input  logic [2:0]        in_port,
	output logic              q_vld,
	output nfr_pkg::item_t    q_item,
	input  logic              pop
);
	import nfr_pkg::*;

	item_t      buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      in_item;

	assign busy  = (cnt_q == 2'd2);
	assign push  = start && !busy;
	assign q_vld = (cnt_q != 2'd0);
	assign q_item = buf_q[rp_q];

	always_comb begin
		in_item.reject   = (protocol != PROTO_TCP && protocol != PROTO_UDP) ||
			!first_fragment || (transport_len < MIN_TRANSPORT_LEN);
		in_item.src_addr = src_addr;
		in_item.dst_addr = dst_addr;
		in_item.src_port = src_port;
		in_item.dst_port = dst_port;
		in_item.in_port  = in_port;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop && q_vld) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop && q_vld);
		end
	end

endmodule

// ----- design/nfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfr_back
// Flow table, linear lookup scan, port allocation and entry insertion.
// ----------------------------------------------------------------------------
module nfr_back #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int OUT_PORTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nfr_pkg::cfg_t     cfg,
	input  logic              q_vld,
	input  nfr_pkg::item_t    q_item,
	output logic              pop,
	output logic              done,
	output nfr_pkg::res_t     res
);
	import nfr_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_START, ST_MOD, ST_PKEY, ST_ALLOC, ST_WR2
	} state_t;
	typedef enum logic [1:0] {PH_FLOW, PH_SAME, PH_PROBE} phase_t;

	state_t  state_q;
	phase_t  phase_q;
	item_t   it_q;
	logic [95:0] srch_q;
	logic [AW:0] idx_q, cnt_q;
	logic        pend_s1;
	logic [95:0] kd_s1;
	logic [98:0] rw_s1;
	logic [15:0] rsp_q, val_q, pcnt_q, lfsr_q, dvd_q;
	logic [16:0] next_off_q, rem_q;
	logic [3:0]  mstep_q;
	logic        done_q;
	res_t        res_q;

	logic [95:0] key_mem [TABLE_ENTRIES];
	logic [98:0] rw_mem  [TABLE_ENTRIES];

	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [95:0] wr_key;
	logic [98:0] wr_rw;
	logic        hit_c, miss_c;
	logic [31:0] rsa_c, rda_c;
	logic [15:0] rsp_c, rdp_c, cand_c, lfsr_nx;
	logic [16:0] div_c, rem_sh;
	logic        full_c;

	function automatic res_t emit(input logic [1:0] act, input logic [2:0] port,
		input logic [31:0] sa, input logic [31:0] da, input logic [15:0] sp,
		input logic [15:0] dp);
		res_t r;
		r.action = act;
		r.out_port = port;
		r.src_addr = sa;
		r.dst_addr = da;
		r.src_port = sp;
		r.dst_port = dp;
		if (act != ACT_DROP && int'(port) >= OUT_PORTS) r.action = ACT_DROP;
		if (r.action == ACT_DROP) begin
			r.out_port = '0;
			r.src_addr = '0;
			r.dst_addr = '0;
			r.src_port = '0;
			r.dst_port = '0;
		end
		return r;
	endfunction

	assign rsa_c = (cfg.new_src_addr != '0) ? cfg.new_src_addr : it_q.src_addr;
	assign rsp_c = (cfg.new_src_port != '0) ? cfg.new_src_port : it_q.src_port;
	assign rda_c = (cfg.new_dst_addr != '0) ? cfg.new_dst_addr : it_q.dst_addr;
	assign rdp_c = (cfg.new_dst_port != '0) ? cfg.new_dst_port : it_q.dst_port;
	assign cand_c = cfg.new_src_port + val_q;
	assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
	assign div_c = {1'b0, cfg.port_span} + 17'd1;
	assign rem_sh = {rem_q[15:0], dvd_q[15]};
	assign full_c = cnt_q > (AW+1)'(TABLE_ENTRIES - 2);

	assign hit_c  = pend_s1 && (kd_s1 == srch_q);
	assign miss_c = !pend_s1 && (idx_q >= cnt_q);
	assign pop    = (state_q == ST_IDLE) && q_vld;
	assign done   = done_q;
	assign res    = res_q;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_key = {it_q.src_addr, it_q.dst_addr, it_q.src_port, it_q.dst_port};
		wr_rw = {rsa_c, rda_c, rsp_q, rdp_c, cfg.forward_port};
		if (state_q == ST_ALLOC && !full_c) begin
			wr_en = 1'b1;
		end else if (state_q == ST_WR2) begin
			wr_en = 1'b1;
			wr_addr = cnt_q[AW-1:0] + AW'(1);
			wr_key = {rda_c, rsa_c, rdp_c, rsp_q};
			wr_rw = {it_q.dst_addr, it_q.src_addr, it_q.dst_port, it_q.src_port,
				cfg.reply_port};
		end
	end

	// table storage: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			rw_mem[wr_addr]  <= wr_rw;
		end
		kd_s1 <= key_mem[idx_q[AW-1:0]];
		rw_s1 <= rw_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FLOW;
			cnt_q <= '0;
			idx_q <= '0;
			pend_s1 <= 1'b0;
			next_off_q <= '0;
			lfsr_q <= LFSR_SEED;
			done_q <= 1'b0;
			res_q <= '0;
			it_q <= '0;
			srch_q <= '0;
			rsp_q <= '0;
			val_q <= '0;
			pcnt_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			mstep_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_vld) begin
						it_q <= q_item;
						if (q_item.reject) begin
							done_q <= 1'b1;
							res_q <= emit(ACT_DROP, '0, '0, '0, '0, '0);
						end else begin
							srch_q <= {q_item.src_addr, q_item.dst_addr,
								q_item.src_port, q_item.dst_port};
							idx_q <= '0;
							pend_s1 <= 1'b0;
							phase_q <= PH_FLOW;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit_c || miss_c) begin
						pend_s1 <= 1'b0;
						case (phase_q)
							PH_FLOW: begin
								if (hit_c) begin
									done_q <= 1'b1;
									res_q <= emit(ACT_FORWARD, rw_s1[2:0], rw_s1[98:67],
										rw_s1[66:35], rw_s1[34:19], rw_s1[18:3]);
									state_q <= ST_IDLE;
								end else if (cfg.rewrite_mode == MODE_DROP) begin
									done_q <= 1'b1;
									res_q <= emit(ACT_DROP, '0, '0, '0, '0, '0);
									state_q <= ST_IDLE;
								end else begin
									rsp_q <= rsp_c;
									if (cfg.port_span == '0) begin
										state_q <= ST_ALLOC;
									end else if (cfg.rewrite_mode == MODE_SAME_RND &&
										it_q.src_port >= cfg.new_src_port &&
										(it_q.src_port - cfg.new_src_port) <= cfg.port_span)
										begin
										srch_q <= {rda_c, rsa_c, rdp_c, it_q.src_port};
										idx_q <= '0;
										phase_q <= PH_SAME;
									end else begin
										state_q <= ST_START;
									end
								end
							end
							PH_SAME: begin
								if (hit_c) begin
									state_q <= ST_START;
								end else begin
									rsp_q <= it_q.src_port;
									state_q <= ST_ALLOC;
								end
							end
							default: begin
								if (miss_c) begin
									rsp_q <= cand_c;
									next_off_q <= {1'b0, val_q} + 17'd1;
									state_q <= ST_ALLOC;
								end else if (pcnt_q == cfg.port_span) begin
									done_q <= 1'b1;
									res_q <= emit(ACT_DROP, '0, '0, '0, '0, '0);
									state_q <= ST_IDLE;
								end else begin
									val_q <= (val_q == cfg.port_span) ? '0 : val_q + 16'd1;
									pcnt_q <= pcnt_q + 16'd1;
									state_q <= ST_PKEY;
								end
							end
						endcase
					end else if (idx_q < cnt_q) begin
						idx_q <= idx_q + (AW+1)'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				ST_START: begin
					pcnt_q <= '0;
					if (cfg.rewrite_mode == MODE_SEQ) begin
						val_q <= (next_off_q > {1'b0, cfg.port_span}) ? '0 :
							next_off_q[15:0];
						state_q <= ST_PKEY;
					end else begin
						lfsr_q <= lfsr_nx;
						dvd_q <= lfsr_nx;
						rem_q <= '0;
						mstep_q <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					// restoring remainder, one dividend bit per cycle
					dvd_q <= {dvd_q[14:0], 1'b0};
					mstep_q <= mstep_q + 4'd1;
					if (rem_sh >= div_c) begin
						rem_q <= rem_sh - div_c;
					end else begin
						rem_q <= rem_sh;
					end
					if (mstep_q == 4'd15) begin
						val_q <= (rem_sh >= div_c) ? 16'(rem_sh - div_c) : rem_sh[15:0];
						state_q <= ST_PKEY;
					end
				end
				ST_PKEY: begin
					srch_q <= {rda_c, rsa_c, rdp_c, cand_c};
					idx_q <= '0;
					pend_s1 <= 1'b0;
					phase_q <= PH_PROBE;
					state_q <= ST_SCAN;
				end
				ST_ALLOC: begin
					if (full_c) begin
						done_q <= 1'b1;
						res_q <= emit(ACT_PASS, it_q.in_port, it_q.src_addr, it_q.dst_addr,
							it_q.src_port, it_q.dst_port);
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WR2;
					end
				end
				ST_WR2: begin
					cnt_q <= cnt_q + (AW+1)'(2);
					done_q <= 1'b1;
					res_q <= emit(ACT_FORWARD, cfg.forward_port, rsa_c, rda_c, rsp_q, rdp_c);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/napt_flow_rewriter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napt_flow_rewriter_unit
// NAPT flow table with source-port allocation, APB configuration.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low; the front
// queue holds two requests, so busy rises only when both slots are taken.
// Each request gives one result, shown for one cycle with done high; the
// receiver cannot stall, so results are never held.
// Rejected requests show their result in the cycle after leaving the queue.
// A lookup scans the filled part of the table one entry a cycle, as the
// single read port of the table memory sets the pace. A new flow adds one
// scan per probed port, a bit-serial remainder for the random start and a
// write of each of the two entries. Reset clears the fill count (table
// empty), the allocation offset and the control registers and seeds the
// LFSR; no clearing pass is needed. Registers sit at paddr 4*i; the user
// must write them only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module napt_flow_rewriter_unit #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int OUT_PORTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  protocol,
	input  logic        first_fragment,
	input  logic [15:0] transport_len,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [2:0]  in_port,
	output logic        done,
	output logic [1:0]  action,
	output logic [2:0]  out_port,
	output logic [31:0] out_src_addr,
	output logic [31:0] out_dst_addr,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port
);
	import nfr_pkg::*;

	cfg_t   cfg_q;
	logic   q_vld, pop;
	item_t  q_item;
	res_t   res;
	logic   wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (paddr[4:2])
				REG_NEW_SRC_ADDR: cfg_q.new_src_addr <= pwdata;
				REG_NEW_SRC_PORT: cfg_q.new_src_port <= pwdata[15:0];
				REG_NEW_DST_ADDR: cfg_q.new_dst_addr <= pwdata;
				REG_NEW_DST_PORT: cfg_q.new_dst_port <= pwdata[15:0];
				REG_PORT_SPAN:    cfg_q.port_span <= pwdata[15:0];
				REG_REWRITE_MODE: cfg_q.rewrite_mode <= pwdata[1:0];
				REG_FORWARD_PORT: cfg_q.forward_port <= pwdata[2:0];
				REG_REPLY_PORT:   cfg_q.reply_port <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_NEW_SRC_ADDR: prdata = cfg_q.new_src_addr;
			REG_NEW_SRC_PORT: prdata = {16'd0, cfg_q.new_src_port};
			REG_NEW_DST_ADDR: prdata = cfg_q.new_dst_addr;
			REG_NEW_DST_PORT: prdata = {16'd0, cfg_q.new_dst_port};
			REG_PORT_SPAN:    prdata = {16'd0, cfg_q.port_span};
			REG_REWRITE_MODE: prdata = {30'd0, cfg_q.rewrite_mode};
			REG_FORWARD_PORT: prdata = {29'd0, cfg_q.forward_port};
			REG_REPLY_PORT:   prdata = {29'd0, cfg_q.reply_port};
			default:          prdata = '0;
		endcase
	end

	nfr_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.protocol(protocol), .first_fragment(first_fragment),
		.transport_len(transport_len), .src_addr(src_addr), .dst_addr(dst_addr),
		.src_port(src_port), .dst_port(dst_port), .in_port(in_port),
		.q_vld(q_vld), .q_item(q_item), .pop(pop)
	);

	nfr_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .OUT_PORTS(OUT_PORTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_vld(q_vld), .q_item(q_item),
		.pop(pop), .done(done), .res(res)
	);

	assign action       = res.action;
	assign out_port     = res.out_port;
	assign out_src_addr = res.src_addr;
	assign out_dst_addr = res.dst_addr;
	assign out_src_port = res.src_port;
	assign out_dst_port = res.dst_port;

endmodule

// ----- tb/sv/napt_flow_rewriter_unit_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napt_flow_rewriter_unit_chk
// Watches the request, register and result channels of the flow rewriter,
// keeps its own flow table, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module napt_flow_rewriter_unit_chk #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int OUT_PORTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic [7:0]  protocol,
	input  logic        first_fragment,
	input  logic [15:0] transport_len,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [2:0]  in_port,
	input  logic        done,
	input  logic [1:0]  action,
	input  logic [2:0]  out_port,
	input  logic [31:0] out_src_addr,
	input  logic [31:0] out_dst_addr,
	input  logic [15:0] out_src_port,
	input  logic [15:0] out_dst_port,
	output int          fail_count,
	output int          pending
);
	import nfr_pkg::*;

	cfg_t        regs;
	logic        tbl_vld [TABLE_ENTRIES];
	logic [63:0] tbl_kaddr [TABLE_ENTRIES];
	logic [31:0] tbl_kport [TABLE_ENTRIES];
	logic [63:0] tbl_raddr [TABLE_ENTRIES];
	logic [31:0] tbl_rport [TABLE_ENTRIES];
	logic [2:0]  tbl_oport [TABLE_ENTRIES];
	logic [16:0] seq_offset;
	logic [15:0] lfsr;
	res_t        rewrite_q[$];

	function automatic int find_flow(logic [63:0] a, logic [31:0] p);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_vld[i] && tbl_kaddr[i] == a && tbl_kport[i] == p)
				return i;
		return -1;
	endfunction

	function automatic res_t make_res(logic [1:0] act, int prt, logic [31:0] sa,
			logic [31:0] da, logic [15:0] sp, logic [15:0] dp);
		res_t r;
		if (act != ACT_DROP && prt >= OUT_PORTS)
			act = ACT_DROP;
		if (act == ACT_DROP) begin
			r = '0;
			r.action = ACT_DROP;
		end else begin
			r.action = act;
			r.out_port = prt[2:0];
			r.src_addr = sa;
			r.dst_addr = da;
			r.src_port = sp;
			r.dst_port = dp;
		end
		return r;
	endfunction

	function automatic res_t rewrite_packet(logic [7:0] pr, logic ff, logic [15:0] tl,
			logic [31:0] sa, logic [31:0] da, logic [15:0] sp, logic [15:0] dp,
			logic [2:0] ip);
		logic [31:0] rsa, rda;
		logic [15:0] rsp, rdp, base, cand;
		logic [63:0] raddrs;
		logic [16:0] val;
		logic        found;
		int          h, f1, f2;
		if ((pr != PROTO_TCP && pr != PROTO_UDP) || !ff || tl < MIN_TRANSPORT_LEN)
			return make_res(ACT_DROP, 0, '0, '0, '0, '0);
		h = find_flow({sa, da}, {sp, dp});
		if (h >= 0)
			return make_res(ACT_FORWARD, int'(tbl_oport[h]), tbl_raddr[h][63:32],
				tbl_raddr[h][31:0], tbl_rport[h][31:16], tbl_rport[h][15:0]);
		if (regs.rewrite_mode == MODE_DROP)
			return make_res(ACT_DROP, 0, '0, '0, '0, '0);
		rsa = regs.new_src_addr != 0 ? regs.new_src_addr : sa;
		rsp = regs.new_src_port != 0 ? regs.new_src_port : sp;
		rda = regs.new_dst_addr != 0 ? regs.new_dst_addr : da;
		rdp = regs.new_dst_port != 0 ? regs.new_dst_port : dp;
		if (regs.port_span != 0) begin
			raddrs = {rda, rsa};
			base = regs.new_src_port;
			found = 1'b0;
			if (regs.rewrite_mode == MODE_SAME_RND && sp >= base
					&& 17'(sp - base) <= regs.port_span
					&& find_flow(raddrs, {rdp, sp}) < 0) begin
				rsp = sp;
				found = 1'b1;
			end
			if (!found) begin
				if (regs.rewrite_mode == MODE_SEQ)
					val = seq_offset > regs.port_span ? 17'd0 : seq_offset;
				else begin
					lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
					val = 17'(lfsr % (17'(regs.port_span) + 17'd1));
				end
				for (int c = 0; c <= regs.port_span; c++) begin
					cand = 16'(base + val);
					if (find_flow(raddrs, {rdp, cand}) < 0) begin
						rsp = cand;
						seq_offset = val + 17'd1;
						found = 1'b1;
						break;
					end
					val = (val == regs.port_span) ? 17'd0 : val + 17'd1;
				end
				if (!found)
					return make_res(ACT_DROP, 0, '0, '0, '0, '0);
			end
		end
		f1 = -1;
		f2 = -1;
		for (int i = 0; i < TABLE_ENTRIES && f2 < 0; i++)
			if (!tbl_vld[i]) begin
				if (f1 < 0) f1 = i;
				else f2 = i;
			end
		if (f2 < 0)
			return make_res(ACT_PASS, int'(ip), sa, da, sp, dp);
		tbl_vld[f1] = 1'b1;
		tbl_kaddr[f1] = {sa, da};
		tbl_kport[f1] = {sp, dp};
		tbl_raddr[f1] = {rsa, rda};
		tbl_rport[f1] = {rsp, rdp};
		tbl_oport[f1] = regs.forward_port;
		tbl_vld[f2] = 1'b1;
		tbl_kaddr[f2] = {rda, rsa};
		tbl_kport[f2] = {rdp, rsp};
		tbl_raddr[f2] = {da, sa};
		tbl_rport[f2] = {dp, sp};
		tbl_oport[f2] = regs.reply_port;
		return make_res(ACT_FORWARD, int'(regs.forward_port), rsa, rda, rsp, rdp);
	endfunction

	assign pending = rewrite_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			regs <= '0;
			seq_offset <= '0;
			lfsr <= LFSR_SEED;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				tbl_vld[i] <= 1'b0;
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready)
				case (paddr[4:2])
					REG_NEW_SRC_ADDR: regs.new_src_addr = pwdata;
					REG_NEW_SRC_PORT: regs.new_src_port = pwdata[15:0];
					REG_NEW_DST_ADDR: regs.new_dst_addr = pwdata;
					REG_NEW_DST_PORT: regs.new_dst_port = pwdata[15:0];
					REG_PORT_SPAN:    regs.port_span = pwdata[15:0];
					REG_REWRITE_MODE: regs.rewrite_mode = pwdata[1:0];
					REG_FORWARD_PORT: regs.forward_port = pwdata[2:0];
					REG_REPLY_PORT:   regs.reply_port = pwdata[2:0];
					default: ;
				endcase
			if (done) begin
				if (rewrite_q.size() == 0) begin
					$display("%0t: result with no request pending: %h", $time,
						{action, out_port, out_src_addr, out_dst_addr,
						out_src_port, out_dst_port});
					fail_count <= fail_count + 1;
				end else begin
					e = rewrite_q.pop_front();
					if (e.action !== action || e.out_port !== out_port
							|| e.src_addr !== out_src_addr
							|| e.dst_addr !== out_dst_addr
							|| e.src_port !== out_src_port
							|| e.dst_port !== out_dst_port) begin
						$display("%0t: mismatch exp act=%0d port=%0d %h:%h -> %h:%h",
							$time, e.action, e.out_port, e.src_addr, e.src_port,
							e.dst_addr, e.dst_port);
						$display("%0t:          got act=%0d port=%0d %h:%h -> %h:%h",
							$time, action, out_port, out_src_addr, out_src_port,
							out_dst_addr, out_dst_port);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				rewrite_q.insert(rewrite_q.size(), rewrite_packet(protocol,
					first_fragment, transport_len, src_addr, dst_addr, src_port,
					dst_port, in_port));
		end
	end

endmodule

// ----- tb/sv/napt_flow_rewriter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napt_flow_rewriter_unit_tb
// Drives packet headers and register writes into the flow rewriter: a
// directed set of corner cases, then phases of random flows with replies
// and repeats under several register settings. The checker judges results.
// ----------------------------------------------------------------------------
module napt_flow_rewriter_unit_tb;
	import nfr_pkg::*;

	// new flows may probe many ports, each probe a scan of the filled table
	localparam int CYCLE_LIMIT = 40000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  protocol = '0;
	logic        first_fragment = 1'b0;
	logic [15:0] transport_len = '0;
	logic [31:0] src_addr = '0, dst_addr = '0;
	logic [15:0] src_port = '0, dst_port = '0;
	logic [2:0]  in_port = '0;
	logic        done;
	logic [1:0]  action;
	logic [2:0]  out_port;
	logic [31:0] out_src_addr, out_dst_addr;
	logic [15:0] out_src_port, out_dst_port;
	int          fail_count, pending;
	int          cycles = 0;
	logic        idle_gaps = 1'b1;

	// recent flows, reused to make hits and reply-direction packets
	logic [31:0] seen_sa[$], seen_da[$];
	logic [15:0] seen_sp[$], seen_dp[$];

	always #10 clk = ~clk;

	napt_flow_rewriter_unit DUT (.*);

	napt_flow_rewriter_unit_chk chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// start stays high between back-to-back requests
	task automatic send_hdr(logic [7:0] pr, logic ff, logic [15:0] tl,
			logic [31:0] sa, logic [31:0] da, logic [15:0] sp, logic [15:0] dp,
			logic [2:0] ip);
		if (idle_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		start <= 1'b1;
		protocol <= pr; first_fragment <= ff; transport_len <= tl;
		src_addr <= sa; dst_addr <= da; src_port <= sp; dst_port <= dp;
		in_port <= ip;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_flow(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp);
		send_hdr($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP, 1'b1,
			16'($urandom_range(8, 65535)), sa, da, sp, dp, 3'($urandom_range(0, 7)));
		seen_sa.insert(seen_sa.size(), sa); seen_da.insert(seen_da.size(), da);
		seen_sp.insert(seen_sp.size(), sp); seen_dp.insert(seen_dp.size(), dp);
		if (seen_sa.size() > 40) begin
			void'(seen_sa.pop_front()); void'(seen_da.pop_front());
			void'(seen_sp.pop_front()); void'(seen_dp.pop_front());
		end
	endtask

	task automatic random_item();
		int k, n;
		k = $urandom_range(0, 9);
		n = seen_sa.size();
		if (k == 0)
			send_hdr(8'($urandom), 1'($urandom), 16'($urandom), $urandom, $urandom,
				16'($urandom), 16'($urandom), 3'($urandom));
		else if (k <= 2 && n > 0) begin
			n = $urandom_range(0, n - 1);
			send_flow(seen_sa[n], seen_da[n], seen_sp[n], seen_dp[n]);
		end else if (k == 3 && n > 0) begin
			n = $urandom_range(0, n - 1);
			send_flow(seen_da[n], seen_sa[n], seen_dp[n], seen_sp[n]);
		end else
			send_flow($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom,
				$urandom_range(0, 7), 16'($urandom_range(0, 1) ?
				$urandom_range(990, 1030) : $urandom), 16'($urandom));
	endtask

	task automatic set_regs(logic [31:0] sa, logic [15:0] sp, logic [31:0] da,
			logic [15:0] dp, logic [15:0] span, logic [1:0] mode, logic [2:0] fp,
			logic [2:0] rp);
		reg_write(REG_NEW_SRC_ADDR, sa);
		reg_write(REG_NEW_SRC_PORT, 32'(sp));
		reg_write(REG_NEW_DST_ADDR, da);
		reg_write(REG_NEW_DST_PORT, 32'(dp));
		reg_write(REG_PORT_SPAN, 32'(span));
		reg_write(REG_REWRITE_MODE, 32'(mode));
		reg_write(REG_FORWARD_PORT, 32'(fp));
		reg_write(REG_REPLY_PORT, 32'(rp));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: rejects, mode drop, then port allocation corners
		send_hdr(8'd1, 1'b1, 16'd100, 32'd1, 32'd2, 16'd3, 16'd4, 3'd0);
		send_hdr(PROTO_TCP, 1'b0, 16'd100, 32'd1, 32'd2, 16'd3, 16'd4, 3'd1);
		send_hdr(PROTO_UDP, 1'b1, 16'd7, 32'd1, 32'd2, 16'd3, 16'd4, 3'd2);
		send_hdr(8'hFF, 1'b1, 16'hFFFF, '1, '1, '1, '1, 3'd7);
		send_flow(32'd1, 32'd2, 16'd3, 16'd4);
		drain();
		set_regs(32'hC0A8_0001, 16'hFFFE, 32'h0A00_0001, 16'd80, 16'd3,
			MODE_SAME_RND, 3'd7, 3'd5);
		send_flow(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_flow('0, '0, '0, '0);
		for (int i = 0; i < 5; i++)
			send_flow(32'h55, 32'h66, 16'(16'hFFFE + i), 16'd9);
		send_flow(32'h0A00_0001, 32'hC0A8_0001, 16'd80, 16'hFFFE);
		send_flow(32'h55, 32'h66, 16'hFFFE, 16'd9);
		drain();
		set_regs('0, 16'd1000, '0, '0, 16'd1, MODE_SEQ, 3'd2, 3'd3);
		for (int i = 0; i < 4; i++)
			send_flow(32'h77, 32'h88, 16'(16'd5 + i), 16'd9);
		drain();
		set_regs('0, '0, '0, '0, 16'hFFFF, MODE_RND, 3'd0, 3'd1);
		for (int i = 0; i < 3; i++)
			send_flow(32'h99, 32'hAA, 16'(16'd100 + i), 16'd9);
		drain();
		// random phases; table eventually fills and passes unchanged
		for (int ph = 0; ph < 12; ph++) begin
			set_regs($urandom_range(0, 1) ? $urandom : 0, 16'($urandom_range(0, 1) ?
				$urandom_range(990, 1020) : 16'hFFF0), $urandom_range(0, 1) ? $urandom
				: 0, 16'($urandom_range(0, 1) ? $urandom : 0), 16'($urandom_range(0, 2) ?
				$urandom_range(0, 12) : 16'hFFFF), 2'($urandom_range(0, 3)),
				3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			if (ph == 11) idle_gaps = 1'b0;
			for (int i = 0; i < 120; i++)
				random_item();
			drain();
		end
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
